// ===== rtl/lsps_pkg.sv =====
`default_nettype none

package lsps_pkg;

    localparam int STARTUP_DELAY     = 50;
    localparam int INIT_SETTLE_DELAY = 50;
    localparam int CONVERSION_DELAY  = 1000;

    localparam int READY_MAX = (STARTUP_DELAY > INIT_SETTLE_DELAY) ?
                               STARTUP_DELAY : INIT_SETTLE_DELAY;
    localparam int TASK_MAX  = (READY_MAX > CONVERSION_DELAY) ? READY_MAX : CONVERSION_DELAY;

    localparam int READY_CNT_W = $clog2(READY_MAX + 1);
    localparam int TASK_CNT_W  = $clog2(TASK_MAX + 1);

    localparam int INTERVAL_W = 32;
    localparam int ADDR_W     = 7;
    localparam int WORD_W     = 16;
    localparam int LUX_W      = 27;
    localparam int MANT_W     = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [INTERVAL_W-1:0] NEVER_INTERVAL = '1;
    localparam logic [ADDR_W-1:0]     BUS_ADDRESS_RESET = 7'd68;

    localparam logic [WORD_W-1:0] WORD_INIT     = 16'hc810;
    localparam logic [WORD_W-1:0] WORD_SINGLE   = 16'hca10;
    localparam logic [WORD_W-1:0] STATUS_MASK   = 16'h0680;
    localparam logic [WORD_W-1:0] STATUS_READY  = 16'h0080;

    localparam logic PTR_RESULT = 1'b0;
    localparam logic PTR_CONFIG = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ADDRESS     = 1'd1;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_MEASURE  = 2'd1,
        MODE_COMPLETE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_TRIGGER  = 3'd1,
        PH_READ_CFG = 3'd2,
        PH_READ_RES = 3'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_REPLY  = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_READ   = 3'd2,
        ACT_UPDATE = 3'd3,
        ACT_ERROR  = 3'd4
    } action_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              bus_ok;
        logic [WORD_W-1:0] bus_read_data;
    } in_t;

    typedef struct packed {
        logic [2:0]        action;
        logic              measure_accepted;
        logic [ADDR_W-1:0] device_address;
        logic              register_pointer;
        logic [WORD_W-1:0] write_word;
        logic [WORD_W-1:0] raw_result;
        logic              result_valid;
        logic [LUX_W-1:0]  lux_hundredths;
    } out_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [INTERVAL_W-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/light_sensor_poll_sequencer.sv =====
// a request waits in the input register; once the result slot is free or being emptied,
//   its result is loaded into the result register
// throughput: one request per cycle while the result side keeps taking results
// reset: asynchronous; sequencer returns to initialize with the startup delay loaded,
//   interval disabled, address 68 and both pipeline registers empty
`default_nettype none

module light_sensor_poll_sequencer
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire lsps_pkg::in_t                      in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output lsps_pkg::out_t                          out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lsps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsps_pkg::INTERVAL_W-1:0]    cfg_data
);

    lsps_pkg::in_t     item_reg;
    logic              item_vld_reg;
    lsps_pkg::out_t    out_reg;
    logic              out_vld_reg;
    logic              advance;
    logic              res_valid;
    lsps_pkg::out_t    res;
    lsps_pkg::cfg_wr_t cfg;

    // the held request moves on once the result slot is free or being emptied
    assign advance   = item_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !item_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= res_valid;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
        if (advance && res_valid)
            out_reg <= res;
    end

    lsps_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item       (item_reg),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

endmodule

`default_nettype wire

// ===== rtl/lsps_core.sv =====
`default_nettype none

module lsps_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire lsps_pkg::in_t    item,
    input  wire lsps_pkg::cfg_wr_t cfg,
    output logic                  res_valid,
    output lsps_pkg::out_t        res
);

    lsps_pkg::phase_t                          phase_reg, phase_next;
    logic                                      awaiting_reg, awaiting_next;
    logic                                      active_reg, active_next;
    logic                                      planned_reg, planned_next;
    logic [lsps_pkg::TASK_CNT_W-1:0]           task_cnt_reg, task_cnt_next;
    logic [lsps_pkg::READY_CNT_W-1:0]          ready_cnt_reg, ready_cnt_next;
    logic [lsps_pkg::INTERVAL_W-1:0]           interval_cnt_reg, interval_cnt_next;
    logic [lsps_pkg::INTERVAL_W-1:0]           interval_reg, interval_next;
    logic [lsps_pkg::ADDR_W-1:0]               address_reg, address_next;
    logic [lsps_pkg::WORD_W-1:0]               result_word_reg, result_word_next;
    logic                                      result_ok_reg, result_ok_next;

    logic                                      emit;
    lsps_pkg::action_t                         emit_action;
    logic                                      emit_accepted;
    logic                                      emit_pointer;
    logic [lsps_pkg::WORD_W-1:0]               emit_word;
    logic                                      accepted;
    logic [lsps_pkg::MANT_W-1:0]               mant;
    logic [3:0]                                expo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lsps_pkg::PH_INIT;
            awaiting_reg     <= 1'b0;
            active_reg       <= 1'b0;
            planned_reg      <= 1'b1;
            task_cnt_reg     <= lsps_pkg::TASK_CNT_W'(lsps_pkg::STARTUP_DELAY);
            ready_cnt_reg    <= lsps_pkg::READY_CNT_W'(lsps_pkg::STARTUP_DELAY);
            interval_cnt_reg <= lsps_pkg::NEVER_INTERVAL;
            interval_reg     <= lsps_pkg::NEVER_INTERVAL;
            address_reg      <= lsps_pkg::BUS_ADDRESS_RESET;
            result_word_reg  <= '0;
            result_ok_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            awaiting_reg     <= awaiting_next;
            active_reg       <= active_next;
            planned_reg      <= planned_next;
            task_cnt_reg     <= task_cnt_next;
            ready_cnt_reg    <= ready_cnt_next;
            interval_cnt_reg <= interval_cnt_next;
            interval_reg     <= interval_next;
            address_reg      <= address_next;
            result_word_reg  <= result_word_next;
            result_ok_reg    <= result_ok_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        awaiting_next     = awaiting_reg;
        active_next       = active_reg;
        planned_next      = planned_reg;
        task_cnt_next     = task_cnt_reg;
        ready_cnt_next    = ready_cnt_reg;
        interval_cnt_next = interval_cnt_reg;
        interval_next     = interval_reg;
        address_next      = address_reg;
        result_word_next  = result_word_reg;
        result_ok_next    = result_ok_reg;
        emit              = 1'b0;
        emit_action       = lsps_pkg::ACT_REPLY;
        emit_accepted     = 1'b0;
        emit_pointer      = lsps_pkg::PTR_RESULT;
        emit_word         = '0;
        accepted          = 1'b0;

        if (item_valid)
        begin
            case (item.mode)
                lsps_pkg::MODE_TICK:
                begin
                    if (ready_cnt_next != '0)
                        ready_cnt_next = ready_cnt_next - 1'b1;
                    if (planned_next && task_cnt_next != '0)
                        task_cnt_next = task_cnt_next - 1'b1;
                    if (interval_reg != lsps_pkg::NEVER_INTERVAL)
                    begin
                        if (interval_cnt_next != '0)
                            interval_cnt_next = interval_cnt_next - 1'b1;
                        if (interval_cnt_next == '0)
                        begin
                            // periodic measure request, reply is dropped
                            if (!active_next)
                            begin
                                active_next = 1'b1;
                                if (!awaiting_next)
                                begin
                                    planned_next  = 1'b1;
                                    task_cnt_next = lsps_pkg::TASK_CNT_W'(ready_cnt_next);
                                end
                            end
                            interval_cnt_next = interval_reg;
                        end
                    end
                    if (planned_next && task_cnt_next == '0 && !awaiting_next)
                    begin
                        planned_next = 1'b0;
                        emit         = 1'b1;
                        case (phase_reg)
                            lsps_pkg::PH_INIT:
                            begin
                                awaiting_next = 1'b1;
                                emit_action   = lsps_pkg::ACT_WRITE;
                                emit_pointer  = lsps_pkg::PTR_CONFIG;
                                emit_word     = lsps_pkg::WORD_INIT;
                            end
                            lsps_pkg::PH_TRIGGER:
                            begin
                                awaiting_next = 1'b1;
                                emit_action   = lsps_pkg::ACT_WRITE;
                                emit_pointer  = lsps_pkg::PTR_CONFIG;
                                emit_word     = lsps_pkg::WORD_SINGLE;
                            end
                            lsps_pkg::PH_READ_CFG:
                            begin
                                awaiting_next = 1'b1;
                                emit_action   = lsps_pkg::ACT_READ;
                                emit_pointer  = lsps_pkg::PTR_CONFIG;
                            end
                            lsps_pkg::PH_READ_RES:
                            begin
                                awaiting_next = 1'b1;
                                emit_action   = lsps_pkg::ACT_READ;
                            end
                            default:
                            begin
                                result_ok_next = 1'b0;
                                active_next    = 1'b0;
                                phase_next     = lsps_pkg::PH_INIT;
                                awaiting_next  = 1'b0;
                                emit_action    = lsps_pkg::ACT_ERROR;
                            end
                        endcase
                    end
                end
                lsps_pkg::MODE_MEASURE:
                begin
                    emit        = 1'b1;
                    emit_action = lsps_pkg::ACT_REPLY;
                    if (!active_reg)
                    begin
                        accepted    = 1'b1;
                        active_next = 1'b1;
                        if (!awaiting_reg)
                        begin
                            planned_next  = 1'b1;
                            task_cnt_next = lsps_pkg::TASK_CNT_W'(ready_cnt_reg);
                        end
                    end
                    emit_accepted = accepted;
                end
                lsps_pkg::MODE_COMPLETE:
                begin
                    // completions with nothing outstanding are dropped
                    if (awaiting_reg)
                    begin
                        awaiting_next = 1'b0;
                        if (!item.bus_ok)
                        begin
                            emit           = 1'b1;
                            emit_action    = lsps_pkg::ACT_ERROR;
                            result_ok_next = 1'b0;
                            active_next    = 1'b0;
                            phase_next     = lsps_pkg::PH_INIT;
                            planned_next   = 1'b0;
                        end
                        else
                        begin
                            case (phase_reg)
                                lsps_pkg::PH_INIT:
                                begin
                                    phase_next     = lsps_pkg::PH_TRIGGER;
                                    ready_cnt_next =
                                        lsps_pkg::READY_CNT_W'(lsps_pkg::INIT_SETTLE_DELAY);
                                    if (active_reg)
                                    begin
                                        planned_next  = 1'b1;
                                        task_cnt_next =
                                            lsps_pkg::TASK_CNT_W'(lsps_pkg::INIT_SETTLE_DELAY);
                                    end
                                end
                                lsps_pkg::PH_TRIGGER:
                                begin
                                    phase_next    = lsps_pkg::PH_READ_CFG;
                                    planned_next  = 1'b1;
                                    task_cnt_next =
                                        lsps_pkg::TASK_CNT_W'(lsps_pkg::CONVERSION_DELAY);
                                end
                                lsps_pkg::PH_READ_CFG:
                                begin
                                    emit = 1'b1;
                                    if ((item.bus_read_data & lsps_pkg::STATUS_MASK)
                                        != lsps_pkg::STATUS_READY)
                                    begin
                                        emit_action    = lsps_pkg::ACT_ERROR;
                                        result_ok_next = 1'b0;
                                        active_next    = 1'b0;
                                        phase_next     = lsps_pkg::PH_INIT;
                                        planned_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next    = lsps_pkg::PH_READ_RES;
                                        awaiting_next = 1'b1;
                                        emit_action   = lsps_pkg::ACT_READ;
                                    end
                                end
                                lsps_pkg::PH_READ_RES:
                                begin
                                    emit             = 1'b1;
                                    emit_action      = lsps_pkg::ACT_UPDATE;
                                    result_word_next = item.bus_read_data;
                                    result_ok_next   = 1'b1;
                                    active_next      = 1'b0;
                                    phase_next       = lsps_pkg::PH_TRIGGER;
                                end
                                default:
                                begin
                                    emit           = 1'b1;
                                    emit_action    = lsps_pkg::ACT_ERROR;
                                    result_ok_next = 1'b0;
                                    active_next    = 1'b0;
                                    phase_next     = lsps_pkg::PH_INIT;
                                    planned_next   = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        // register writes must come only while no request is in flight; the core does not enforce this
        if (cfg.valid)
        begin
            case (cfg.index)
                lsps_pkg::CFG_UPDATE_INTERVAL:
                begin
                    interval_next     = cfg.data;
                    interval_cnt_next = cfg.data;
                    if (cfg.data != lsps_pkg::NEVER_INTERVAL && !active_next)
                    begin
                        active_next = 1'b1;
                        if (!awaiting_next)
                        begin
                            planned_next  = 1'b1;
                            task_cnt_next = lsps_pkg::TASK_CNT_W'(ready_cnt_next);
                        end
                    end
                end
                lsps_pkg::CFG_BUS_ADDRESS:
                begin
                    address_next = cfg.data[lsps_pkg::ADDR_W-1:0];
                end
                default:
                begin
                    address_next = address_reg;
                end
            endcase
        end
    end

    assign mant = result_word_next[lsps_pkg::MANT_W-1:0];
    assign expo = result_word_next[lsps_pkg::WORD_W-1:lsps_pkg::MANT_W];

    always_comb
    begin
        res_valid            = emit;
        res.action           = emit_action;
        res.measure_accepted = emit_accepted;
        res.device_address   = address_reg;
        res.register_pointer = emit_pointer;
        res.write_word       = emit_word;
        res.result_valid     = result_ok_next;
        res.raw_result       = result_ok_next ? result_word_next : '0;
        res.lux_hundredths   = result_ok_next ?
            ({{(lsps_pkg::LUX_W-lsps_pkg::MANT_W){1'b0}}, mant} << expo) : '0;
    end

`ifndef SYNTHESIS
    a_request_sets_awaiting: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.action == lsps_pkg::ACT_WRITE || res.action == lsps_pkg::ACT_READ))
        |=> awaiting_reg)
        else $error("bus request issued without marking it outstanding");

    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.action == lsps_pkg::ACT_ERROR && !cfg.valid)
        |=> (!active_reg && !result_ok_reg && !awaiting_reg && phase_reg == lsps_pkg::PH_INIT))
        else $error("error event did not return to initialize");

    a_update_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.action == lsps_pkg::ACT_UPDATE)
        |=> (result_ok_reg && result_word_reg == $past(item.bus_read_data)))
        else $error("update event without stored result");
`endif

endmodule

`default_nettype wire
